// File: hdl/leg_forward_kinematics_top_defines.svh
// Assertion helpers for the leg kinematics top-level RTL
`ifndef LEG_FORWARD_KINEMATICS_TOP_DEFINES_SVH
`define LEG_FORWARD_KINEMATICS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define LFK_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define LFK_NEVER(lbl, clk_s, rst_s, cond, msg) \
    `LFK_ASSERT(lbl, clk_s, rst_s, !(cond), msg)
`else
`define LFK_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define LFK_NEVER(lbl, clk_s, rst_s, cond, msg)
`endif

`endif

// File: hdl/lfk_pkg.sv
`default_nettype none
package lfk_pkg;

    localparam int CORDIC_STEPS       = 24;
    localparam int CORDIC_LAT         = CORDIC_STEPS + 2;
    localparam int ANGLE_BITS_DEFAULT = 16;
    localparam int XW                 = 34;
    localparam int ZW                 = 33;
    localparam int TW                 = 17;
    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [2:0] REG_BODY_LENGTH  = 3'd0;
    localparam logic [2:0] REG_BODY_WIDTH   = 3'd1;
    localparam logic [2:0] REG_HIP_DROP     = 3'd2;
    localparam logic [2:0] REG_THIGH_LENGTH = 3'd3;
    localparam logic [2:0] REG_CALF_LENGTH  = 3'd4;
    localparam logic [2:0] REG_FOOT_LENGTH  = 3'd5;

    typedef struct packed {
        logic signed [TW-1:0] cs;
        logic signed [TW-1:0] sn;
    } trig_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input int i);
        logic [29:0] a;
        case (i)
            0: a = 30'd536870912;
            1: a = 30'd316933406;
            2: a = 30'd167458907;
            3: a = 30'd85004756;
            4: a = 30'd42667331;
            5: a = 30'd21354465;
            6: a = 30'd10679838;
            7: a = 30'd5340245;
            8: a = 30'd2670163;
            9: a = 30'd1335087;
            10: a = 30'd667544;
            11: a = 30'd333772;
            12: a = 30'd166886;
            13: a = 30'd83443;
            14: a = 30'd41722;
            15: a = 30'd20861;
            16: a = 30'd10430;
            17: a = 30'd5215;
            18: a = 30'd2608;
            19: a = 30'd1304;
            20: a = 30'd652;
            21: a = 30'd326;
            22: a = 30'd163;
            23: a = 30'd81;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

    // Q4.30 to Q1.15, half away from zero, clamped
    function automatic logic signed [TW-1:0] to_q15(input logic signed [XW-1:0] v);
        logic signed [XW:0] a;
        logic signed [XW:0] r;
        if (!v[XW-1]) begin
            a = {v[XW-1], v} + (XW+1)'(16384);
            r = a >>> 15;
        end
        else begin
            a = -{v[XW-1], v} + (XW+1)'(16384);
            r = -(a >>> 15);
        end
        if (r > $signed((XW+1)'(32767)))
            r = (XW+1)'(32767);
        if (r < -$signed((XW+1)'(32768)))
            r = -$signed((XW+1)'(32768));
        return TW'(r);
    endfunction

endpackage
`default_nettype wire

// File: hdl/leg_forward_kinematics_top.sv
// Foot position of one leg from its hip, thigh and calf angles. One item enters per cycle
// while the output is not stalled. Each item passes the three parallel 24-step CORDIC
// pipelines (input stage, one rotation per stage, rounding stage), then four stages of
// link products, sums, the hip rotation and the final round. The whole pipeline holds
// while a finished result waits, so item_ready follows result_ready whenever the output
// register is full. Link lengths sit in six APB registers at byte addresses 0 to 20.
`default_nettype none
`include "leg_forward_kinematics_top_defines.svh"
module leg_forward_kinematics_top #(
    parameter int ANGLE_BITS = lfk_pkg::ANGLE_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic [1:0]         leg,
    input  wire logic signed [15:0] hip_angle,
    input  wire logic signed [15:0] thigh_angle,
    input  wire logic signed [15:0] calf_angle,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic signed [19:0]      foot_x,
    output logic signed [19:0]      foot_y,
    output logic signed [19:0]      foot_z,
    output logic [1:0]              which_leg
);

    localparam int          KEEP  = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
    localparam logic [15:0] AMASK = 16'(16'hFFFF << (16 - KEEP));
    localparam int          CL    = lfk_pkg::CORDIC_LAT;
    localparam int          P     = CL + 4;
    localparam int          SW    = 55;

    logic [15:0] body_length_reg, body_width_reg, hip_drop_reg;
    logic [15:0] thigh_length_reg, calf_length_reg, foot_length_reg;

    logic            adv;
    logic [P-1:0]    vld_reg;
    logic [1:0]      leg_reg [0:P-1];
    logic [15:0]     tc_sum;
    lfk_pkg::trig_t  trig_h, trig_t, trig_tc;
    logic [16:0]     lower;

    logic signed [33:0] pt_c_reg, pt_s_reg;
    logic signed [34:0] pl_c_reg, pl_s_reg;
    logic signed [16:0] ch1_reg, sh1_reg, ch2_reg, sh2_reg;
    logic signed [35:0] reach_reg, lift_reg;
    logic signed [52:0] px_reg, py_reg;
    logic signed [50:0] pz_reg;
    logic signed [SW-1:0] bx, by, sx, sy, sz;
    logic signed [19:0] foot_x_reg, foot_y_reg, foot_z_reg;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_length_reg  <= '0;
            body_width_reg   <= '0;
            hip_drop_reg     <= '0;
            thigh_length_reg <= '0;
            calf_length_reg  <= '0;
            foot_length_reg  <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[4:2])
                lfk_pkg::REG_BODY_LENGTH:  body_length_reg  <= pwdata[15:0];
                lfk_pkg::REG_BODY_WIDTH:   body_width_reg   <= pwdata[15:0];
                lfk_pkg::REG_HIP_DROP:     hip_drop_reg     <= pwdata[15:0];
                lfk_pkg::REG_THIGH_LENGTH: thigh_length_reg <= pwdata[15:0];
                lfk_pkg::REG_CALF_LENGTH:  calf_length_reg  <= pwdata[15:0];
                lfk_pkg::REG_FOOT_LENGTH:  foot_length_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            lfk_pkg::REG_BODY_LENGTH:  prdata = {16'h0, body_length_reg};
            lfk_pkg::REG_BODY_WIDTH:   prdata = {16'h0, body_width_reg};
            lfk_pkg::REG_HIP_DROP:     prdata = {16'h0, hip_drop_reg};
            lfk_pkg::REG_THIGH_LENGTH: prdata = {16'h0, thigh_length_reg};
            lfk_pkg::REG_CALF_LENGTH:  prdata = {16'h0, calf_length_reg};
            lfk_pkg::REG_FOOT_LENGTH:  prdata = {16'h0, foot_length_reg};
            default:                   prdata = '0;
        endcase
    end

    // advance everything unless a result waits
    assign adv        = !vld_reg[P-1] || result_ready;
    assign item_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[P-2:0], item_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            leg_reg[0] <= leg;
            for (int i = 1; i < P; i++)
                leg_reg[i] <= leg_reg[i-1];
        end
    end

    assign tc_sum = 16'(thigh_angle + calf_angle);

    lfk_cordic u_cordic_h (
        .clk   (clk),
        .en    (adv),
        .angle (hip_angle & AMASK),
        .trig  (trig_h)
    );

    lfk_cordic u_cordic_t (
        .clk   (clk),
        .en    (adv),
        .angle (thigh_angle & AMASK),
        .trig  (trig_t)
    );

    lfk_cordic u_cordic_tc (
        .clk   (clk),
        .en    (adv),
        .angle (tc_sum & AMASK),
        .trig  (trig_tc)
    );

    assign lower = {1'b0, calf_length_reg} + {1'b0, foot_length_reg};

    // link products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_c_reg <= $signed({1'b0, thigh_length_reg}) * trig_t.cs;
            pt_s_reg <= $signed({1'b0, thigh_length_reg}) * trig_t.sn;
            pl_c_reg <= $signed({1'b0, lower}) * trig_tc.cs;
            pl_s_reg <= $signed({1'b0, lower}) * trig_tc.sn;
            ch1_reg  <= trig_h.cs;
            sh1_reg  <= trig_h.sn;
        end
    end

    // reach and lift
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            reach_reg <= 36'(pt_c_reg) + 36'(pl_c_reg);
            lift_reg  <= 36'(pt_s_reg) + 36'(pl_s_reg);
            ch2_reg   <= ch1_reg;
            sh2_reg   <= sh1_reg;
        end
    end

    // hip rotation
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= reach_reg * ch2_reg;
            py_reg <= reach_reg * sh2_reg;
            pz_reg <= 51'(lift_reg) <<< 15;
        end
    end

    // add the hip base and round to 2^-16 m, ties upward
    always_comb
    begin
        bx = $signed({10'h0, body_length_reg, 29'h0});
        by = $signed({10'h0, body_width_reg, 29'h0});
        if (leg_reg[P-2][1])
            bx = -bx;
        if (leg_reg[P-2][0])
            by = -by;
        sx = bx + SW'(px_reg) + (SW'(1) <<< 29);
        sy = by + SW'(py_reg) + (SW'(1) <<< 29);
        sz = -$signed({9'h0, hip_drop_reg, 30'h0}) - SW'(pz_reg) + (SW'(1) <<< 29);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            foot_x_reg <= sx[49:30];
            foot_y_reg <= sy[49:30];
            foot_z_reg <= sz[49:30];
        end
    end

    assign result_valid = vld_reg[P-1];
    assign foot_x       = foot_x_reg;
    assign foot_y       = foot_y_reg;
    assign foot_z       = foot_z_reg;
    assign which_leg    = leg_reg[P-1];

    `LFK_ASSERT(a_stall_hold, clk, rst_n, !adv |=> $stable(vld_reg), "pipeline moved in a stall")
    `LFK_ASSERT(a_out_source, clk, rst_n, $rose(result_valid) |-> $past(vld_reg[P-2]), "result from nowhere")
    `LFK_ASSERT(a_enter, clk, rst_n, (item_valid && item_ready) |=> vld_reg[0], "item lost at entry")
    `LFK_NEVER(a_blocked, clk, rst_n, item_ready && result_valid && !result_ready, "took item while blocked")

endmodule
`default_nettype wire

// File: hdl/lfk_cordic.sv
`default_nettype none
module lfk_cordic (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [15:0]    angle,
    output lfk_pkg::trig_t      trig
);

    localparam int N = lfk_pkg::CORDIC_STEPS;

    logic signed [lfk_pkg::XW-1:0] x_reg [0:N];
    logic signed [lfk_pkg::XW-1:0] y_reg [0:N];
    logic signed [lfk_pkg::ZW-1:0] z_reg [0:N];
    logic [1:0]                    quad_reg [0:N];
    lfk_pkg::trig_t                trig_reg;
    lfk_pkg::trig_t                trig_next;
    logic signed [lfk_pkg::TW-1:0] c_q;
    logic signed [lfk_pkg::TW-1:0] s_q;

    // load the quarter-turn remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= lfk_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({3'b000, angle[13:0], 16'h0000});
            quad_reg[0] <= angle[15:14];
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_step
        localparam logic signed [lfk_pkg::ZW-1:0] ATAN =
            $signed({3'b000, lfk_pkg::atan_turn(g)});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[g][lfk_pkg::ZW-1])
                begin
                    x_reg[g+1] <= x_reg[g] - (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] + (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] - ATAN;
                end
                else
                begin
                    x_reg[g+1] <= x_reg[g] + (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] - (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] + ATAN;
                end
                quad_reg[g+1] <= quad_reg[g];
            end
        end
    end

    // round, then fold back into the right quadrant
    always_comb
    begin
        c_q = lfk_pkg::to_q15(x_reg[N]);
        s_q = lfk_pkg::to_q15(y_reg[N]);
        case (quad_reg[N])
            lfk_pkg::QUAD_0: begin trig_next.cs = c_q;  trig_next.sn = s_q;  end
            lfk_pkg::QUAD_1: begin trig_next.cs = -s_q; trig_next.sn = c_q;  end
            lfk_pkg::QUAD_2: begin trig_next.cs = -c_q; trig_next.sn = -s_q; end
            default:         begin trig_next.cs = s_q;  trig_next.sn = -c_q; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            trig_reg <= trig_next;
    end

    assign trig = trig_reg;

endmodule
`default_nettype wire

// File: dv/leg_forward_kinematics_top_test.sv
`timescale 1ns / 1ps
module leg_forward_kinematics_top_test;

    typedef struct packed {
        logic [19:0] x;
        logic [19:0] y;
        logic [19:0] z;
        logic [1:0]  leg;
    } foot_pos_t;

    typedef struct {
        int          setting;
        logic [1:0]  leg;
        logic [15:0] hip;
        logic [15:0] thigh;
        logic [15:0] calf;
        bit          typed;
        foot_pos_t   pos;
    } leg_row_t;

    localparam longint ARCTAN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };
    localparam logic [2:0] LINK_REGS [6] = '{
        lfk_pkg::REG_BODY_LENGTH, lfk_pkg::REG_BODY_WIDTH, lfk_pkg::REG_HIP_DROP,
        lfk_pkg::REG_THIGH_LENGTH, lfk_pkg::REG_CALF_LENGTH, lfk_pkg::REG_FOOT_LENGTH
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid;
    logic        item_ready;
    logic [1:0]  leg;
    logic signed [15:0] hip_angle;
    logic signed [15:0] thigh_angle;
    logic signed [15:0] calf_angle;
    logic        result_valid;
    logic        result_ready;
    logic signed [19:0] foot_x;
    logic signed [19:0] foot_y;
    logic signed [19:0] foot_z;
    logic [1:0]  which_leg;

    logic [15:0] link_len [6];
    foot_pos_t   pending_feet [$];
    int          mismatches;

    leg_forward_kinematics_top dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_ready(item_ready), .leg(leg),
        .hip_angle(hip_angle), .thigh_angle(thigh_angle), .calf_angle(calf_angle),
        .result_valid(result_valid), .result_ready(result_ready),
        .foot_x(foot_x), .foot_y(foot_y), .foot_z(foot_z), .which_leg(which_leg)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint q15_round(longint v);
        longint r;
        if (v >= 0)
            r = (v + 16384) >>> 15;
        else
            r = -((-v + 16384) >>> 15);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    function automatic void sin_cos(input logic [15:0] ang, output longint cs,
                                    output longint sn);
        logic [31:0] turn;
        longint x, y, z, nx, c, s;
        turn = {ang, 16'h0000};
        x = 652032874;
        y = 0;
        z = longint'(turn[29:0]);
        for (int i = 0; i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ARCTAN[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ARCTAN[i];
            end
            x = nx;
        end
        c = q15_round(x);
        s = q15_round(y);
        case (turn[31:30])
            lfk_pkg::QUAD_0: begin cs = c;  sn = s;  end
            lfk_pkg::QUAD_1: begin cs = -s; sn = c;  end
            lfk_pkg::QUAD_2: begin cs = -c; sn = -s; end
            default:         begin cs = s;  sn = -c; end
        endcase
    endfunction

    function automatic logic [19:0] to_metres(longint v);
        longint r;
        r = (v + (longint'(1) <<< 29)) >>> 30;
        return r[19:0];
    endfunction

    function automatic foot_pos_t foot_position(logic [1:0] lg, logic [15:0] h,
                                                logic [15:0] t, logic [15:0] c);
        longint ch, sh, ct, st, ctc, stc, lower, reach, lift, bx, by;
        logic [15:0] tc;
        foot_pos_t p;
        tc = t + c;
        sin_cos(h, ch, sh);
        sin_cos(t, ct, st);
        sin_cos(tc, ctc, stc);
        lower = longint'(link_len[4]) + longint'(link_len[5]);
        reach = longint'(link_len[3]) * ct + lower * ctc;
        lift  = longint'(link_len[3]) * st + lower * stc;
        bx = longint'(link_len[0]) <<< 29;
        by = longint'(link_len[1]) <<< 29;
        if (lg[1])
            bx = -bx;
        if (lg[0])
            by = -by;
        p.x = to_metres(bx + reach * ch);
        p.y = to_metres(by + reach * sh);
        p.z = to_metres(-(longint'(link_len[2]) <<< 30) - lift * 32768);
        p.leg = lg;
        return p;
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [15:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom_range(65535)), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[15:0] !== val)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("register %0d reads %h, wrote %h", idx, prdata[15:0], val);
        end
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        link_len[idx] = val;
    endtask

    task automatic drain();
        while (pending_feet.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // 0: all zero, 1: body only at maximum, 2: all at maximum, else random
    task automatic set_links(int setting);
        logic [15:0] v;
        for (int i = 0; i < 6; i++)
        begin
            case (setting)
                0: v = 16'h0000;
                1: v = (i < 2) ? 16'hFFFF : 16'h0000;
                2: v = 16'hFFFF;
                default: v = 16'($urandom_range(65535));
            endcase
            apb_write(LINK_REGS[i], v);
        end
    endtask

    task automatic send_leg(logic [1:0] lg, logic [15:0] h, logic [15:0] t,
                            logic [15:0] c, bit typed, foot_pos_t pos);
        int gap;
        item_valid <= 1'b1;
        leg <= lg;
        hip_angle <= h;
        thigh_angle <= t;
        calf_angle <= c;
        do
            @(negedge clk);
        while (!item_ready);
        @(posedge clk);
        pending_feet.push_back(typed ? pos : foot_position(lg, h, t, c));
        gap = ($urandom_range(3) == 0) ? (($urandom_range(9) == 0) ?
              $urandom_range(40) : $urandom_range(3)) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return {2'($urandom_range(3)), 14'h0000};
            4: return 16'($urandom_range(64)) - 16'd32;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    initial
    begin
        static foot_pos_t zero_pos = '0;
        leg_row_t rows [$];
        int cur_setting;
        foot_pos_t p;

        // after reset every length is zero, then only the body half offsets remain
        for (int k = 0; k < 4; k++)
        begin
            p = '0;
            p.leg = 2'(k);
            rows.push_back('{0, 2'(k), 16'h7FFF, 16'h8000, 16'h1234, 1'b1, p});
        end
        rows.push_back('{1, 2'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                         '{20'd32768, 20'd32768, 20'd0, 2'd0}});
        rows.push_back('{1, 2'd1, 16'h4000, 16'hC000, 16'h8000, 1'b1,
                         '{20'd32768, -20'sd32767, 20'd0, 2'd1}});
        rows.push_back('{1, 2'd2, 16'h8000, 16'h7FFF, 16'h0001, 1'b1,
                         '{-20'sd32767, 20'd32768, 20'd0, 2'd2}});
        rows.push_back('{1, 2'd3, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b1,
                         '{-20'sd32767, -20'sd32767, 20'd0, 2'd3}});
        rows.push_back('{2, 2'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, zero_pos});
        rows.push_back('{2, 2'd1, 16'h4000, 16'h4000, 16'h4000, 1'b0, zero_pos});
        rows.push_back('{2, 2'd2, 16'h8000, 16'h8000, 16'h8000, 1'b0, zero_pos});
        rows.push_back('{2, 2'd3, 16'hC000, 16'hC000, 16'hC000, 1'b0, zero_pos});
        rows.push_back('{2, 2'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, zero_pos});
        rows.push_back('{2, 2'd1, 16'h8001, 16'h8001, 16'hFFFF, 1'b0, zero_pos});
        rows.push_back('{2, 2'd2, 16'hFFFF, 16'hC000, 16'h4000, 1'b0, zero_pos});
        rows.push_back('{2, 2'd3, 16'h0001, 16'h2000, 16'hE000, 1'b0, zero_pos});
        rows.push_back('{2, 2'd0, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, zero_pos});
        rows.push_back('{2, 2'd3, 16'hAAAA, 16'h5555, 16'hAAAB, 1'b0, zero_pos});

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        leg = '0;
        hip_angle = '0;
        thigh_angle = '0;
        calf_angle = '0;
        mismatches = 0;
        for (int i = 0; i < 6; i++)
            link_len[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_setting = 0;
        foreach (rows[i])
        begin
            if (rows[i].setting != cur_setting)
            begin
                item_valid <= 1'b0;
                drain();
                cur_setting = rows[i].setting;
                set_links(cur_setting);
            end
            send_leg(rows[i].leg, rows[i].hip, rows[i].thigh, rows[i].calf,
                     rows[i].typed, rows[i].pos);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            item_valid <= 1'b0;
            drain();
            set_links((ph == 1) ? 0 : (ph == 3) ? 2 : 3);
            for (int n = 0; n < 125; n++)
                send_leg(2'($urandom_range(3)), pick_angle(), pick_angle(), pick_angle(),
                         1'b0, zero_pos);
        end
        item_valid <= 1'b0;
        drain();
        if (mismatches == 0)
            $display("PASS leg_forward_kinematics_top");
        else
            $display("FAIL leg_forward_kinematics_top");
        $finish;
    end

    // result side: random stalls, mostly short, now and then a long one
    initial
    begin
        int stall;
        foot_pos_t want;
        result_ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (result_valid && result_ready)
            begin
                if (pending_feet.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: x %h y %h z %h leg %0d",
                                 foot_x, foot_y, foot_z, which_leg);
                end
                else
                begin
                    want = pending_feet.pop_front();
                    if (foot_x !== want.x || foot_y !== want.y ||
                        foot_z !== want.z || which_leg !== want.leg)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("foot mismatch: want x %h y %h z %h leg %0d, %s",
                                     want.x, want.y, want.z, want.leg,
                                     $sformatf("got x %h y %h z %h leg %0d",
                                               foot_x, foot_y, foot_z, which_leg));
                    end
                end
            end
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                result_ready <= 1'b0;
            end
            else if ($urandom_range(4) == 0)
            begin
                stall = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(3);
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        #5000000;
        $display("FAIL leg_forward_kinematics_top");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/lfk_pkg.sv
hdl/lfk_cordic.sv
hdl/leg_forward_kinematics_top.sv
dv/leg_forward_kinematics_top_test.sv
